/* src/servo_pulse_ramp_macros.svh */
// Assertion macros for the servo pulse ramp.
// Both expect a clock named clock and a synchronous reset named reset in scope.
`ifndef SERVO_PULSE_RAMP_MACROS_SVH
`define SERVO_PULSE_RAMP_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SRV_ASSERT_IMP(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define SRV_ASSERT_NXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* src/srv_pkg.sv */
`default_nettype none

package srv_pkg;

   // Width of every count, limit and position value.
   localparam int unsigned VAL_W = 16;

   // Command kinds carried on req_tuser.
   localparam int unsigned FUNC_W = 2;
   localparam logic [FUNC_W-1:0] FUNC_TICK = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_MOVE = 2'd1;
   localparam logic [FUNC_W-1:0] FUNC_SET  = 2'd2;

   // Configuration register indexes.
   localparam int unsigned CSR_IDX_W = 2;
   localparam logic [CSR_IDX_W-1:0] REG_ENABLE   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_PERIOD   = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_LIMIT_MIN = 2'd2;
   localparam logic [CSR_IDX_W-1:0] REG_LIMIT_MAX = 2'd3;

   // Stream payload widths, rounded up to whole bytes.
   localparam int unsigned REQ_DATA_W = 32;
   localparam int unsigned RSP_DATA_W = 40;

endpackage

`default_nettype wire

/* src/srv_mul.sv */
`default_nettype none

// Shift-and-add multiplier: one multiplier bit per cycle.
module srv_mul #(
   parameter int unsigned W = srv_pkg::VAL_W
) (
   input  logic           clock,
   input  logic           reset,
   input  logic           start,
   input  logic [W-1:0]   mcand,
   input  logic [W-1:0]   mplr,
   output logic           done,
   output logic [2*W-1:0] product
);

   localparam int unsigned CntW = (W > 1) ? $clog2(W) : 1;

   logic [2*W-1:0] p_ff, p_in;
   logic [W-1:0]   mcand_ff, mcand_in;
   logic [CntW-1:0] cnt_ff, cnt_in;
   logic           busy_ff, busy_in;
   logic           done_ff, done_in;
   logic [W:0]     sum;

   always_comb begin
      p_in     = p_ff;
      mcand_in = mcand_ff;
      cnt_in   = cnt_ff;
      busy_in  = busy_ff;
      done_in  = 1'b0;
      sum      = {1'b0, p_ff[2*W-1:W]} + {1'b0, mcand_ff};
      if (start) begin
         p_in     = {{W{1'b0}}, mplr};
         mcand_in = mcand;
         cnt_in   = '0;
         busy_in  = 1'b1;
      end else if (busy_ff) begin
         if (p_ff[0]) begin
            p_in = {sum, p_ff[W-1:1]};
         end else begin
            p_in = {1'b0, p_ff[2*W-1:1]};
         end
         cnt_in = cnt_ff + CntW'(1);
         if (cnt_ff == CntW'(W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      p_ff     <= p_in;
      mcand_ff <= mcand_in;
   end

   assign done    = done_ff;
   assign product = p_ff;

endmodule

`default_nettype wire

/* src/srv_div.sv */
`default_nettype none

// Restoring divider, one quotient bit per cycle. The upper half of the
// dividend must be below the divisor, so the quotient fits in W bits.
module srv_div #(
   parameter int unsigned W = srv_pkg::VAL_W
) (
   input  logic           clock,
   input  logic           reset,
   input  logic           start,
   input  logic [2*W-1:0] dividend,
   input  logic [W-1:0]   divisor,
   output logic           done,
   output logic [W-1:0]   quotient
);

   localparam int unsigned CntW = (W > 1) ? $clog2(W) : 1;

   logic [W-1:0]    rem_ff, rem_in;
   logic [W-1:0]    dvd_ff, dvd_in;
   logic [W-1:0]    dvs_ff, dvs_in;
   logic [CntW-1:0] cnt_ff, cnt_in;
   logic            busy_ff, busy_in;
   logic            done_ff, done_in;
   logic [W:0]      trial;
   logic [W+1:0]    diff;
   logic            ge;

   always_comb begin
      rem_in  = rem_ff;
      dvd_in  = dvd_ff;
      dvs_in  = dvs_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      trial   = {rem_ff, dvd_ff[W-1]};
      diff    = {1'b0, trial} - {2'b00, dvs_ff};
      ge      = ~diff[W+1];
      if (start) begin
         rem_in  = dividend[2*W-1:W];
         dvd_in  = dividend[W-1:0];
         dvs_in  = divisor;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in = ge ? diff[W-1:0] : trial[W-1:0];
         dvd_in = {dvd_ff[W-2:0], ge};
         cnt_in = cnt_ff + CntW'(1);
         if (cnt_ff == CntW'(W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      dvd_ff <= dvd_in;
      dvs_ff <= dvs_in;
   end

   assign done     = done_ff;
   assign quotient = dvd_ff;

endmodule

`default_nettype wire

/* src/servo_pulse_ramp.sv */
// A ramp tick runs from acceptance through the multiply steps, a hand-off to the
// divider, the divide steps, a position update and the load of the output
// register; any other item goes straight to the output register.
// The block takes one item at a time: a new item is taken only after the last
// result has been loaded into the output register, and that load waits while
// the result side stalls.
// Reset is synchronous and active high; it clears the position state and
// returns the registers to enable 0, period 0, minimum 0 and maximum 65535.
`default_nettype none

`include "servo_pulse_ramp_macros.svh"

module servo_pulse_ramp (
   input  logic                             clock,
   input  logic                             reset,
   // Input stream of commands.
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [srv_pkg::REQ_DATA_W-1:0]   req_tdata,  // target_high[15:0], step_count[31:16]
   input  logic [srv_pkg::FUNC_W-1:0]       req_tuser,  // func[1:0]
   // Result stream, one item per command.
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [srv_pkg::RSP_DATA_W-1:0]   rsp_tdata,  // high_count[15:0], low_count[31:16],
                                                        // updated[32], moving[33], zero[39:34]
   // Configuration write port.
   input  logic                             csr_we,
   input  logic [srv_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [srv_pkg::VAL_W-1:0]        csr_wdata
);

   import srv_pkg::*;

   // Controller states. The block takes a new item only in S_IDLE; S_MUL and
   // S_DIV wait for the serial units, and S_OUT hands the result to the output
   // register as soon as that register is free.
   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_MUL  = 2'd1;
   localparam logic [1:0] S_DIV  = 2'd2;
   localparam logic [1:0] S_OUT  = 2'd3;

   logic [1:0]       state_ff, state_in;

   // Configuration registers.
   logic             enable_ff, enable_in;
   logic [VAL_W-1:0] period_ff, period_in;
   logic [VAL_W-1:0] lim_min_ff, lim_min_in;
   logic [VAL_W-1:0] lim_max_ff, lim_max_in;

   // Ramp state.
   logic [VAL_W-1:0] now_ff, now_in;
   logic [VAL_W-1:0] start_ff, start_in;
   logic [VAL_W-1:0] target_ff, target_in;
   logic [VAL_W-1:0] idx_ff, idx_in;
   logic [VAL_W-1:0] total_ff, total_in;
   logic             neg_ff, neg_in;
   logic             upd_ff, upd_in;

   // Output register.
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;

   // Serial arithmetic.
   logic               mul_start, mul_done;
   logic [VAL_W-1:0]   mul_mcand, mul_mplr;
   logic [2*VAL_W-1:0] mul_product;
   logic               div_start, div_done;
   logic [VAL_W-1:0]   div_quot;

   // Helpers.
   logic [FUNC_W-1:0] req_func;
   logic [VAL_W-1:0]  req_target, req_steps, tgt_clamped;
   logic              accept;
   logic [VAL_W:0]    ramp_up, ramp_down;
   logic [VAL_W-1:0]  ramp_raw, ramp_clamped;
   logic [VAL_W:0]    low_diff;
   logic [VAL_W-1:0]  low_count;
   logic              moving;

   assign req_func   = req_tuser;
   assign req_target = req_tdata[VAL_W-1:0];
   assign req_steps  = req_tdata[2*VAL_W-1:VAL_W];
   assign req_tready = (state_ff == S_IDLE);
   assign accept     = req_tvalid && req_tready;

   // A move target is checked against the minimum first, then the maximum.
   always_comb begin
      if (req_target < lim_min_ff) begin
         tgt_clamped = lim_min_ff;
      end else if (req_target > lim_max_ff) begin
         tgt_clamped = lim_max_ff;
      end else begin
         tgt_clamped = req_target;
      end
   end

   // The quotient is the magnitude of the step away from the start; the sign of
   // the ramp was kept in neg_ff. A ramp tick checks the maximum first, so with
   // inverted limits the maximum wins.
   always_comb begin
      ramp_up   = {1'b0, start_ff} + {1'b0, div_quot};
      ramp_down = {1'b0, start_ff} - {1'b0, div_quot};
      if (neg_ff) begin
         ramp_raw = ramp_down[VAL_W] ? '0 : ramp_down[VAL_W-1:0];
      end else begin
         ramp_raw = ramp_up[VAL_W] ? '1 : ramp_up[VAL_W-1:0];
      end
      if (ramp_raw > lim_max_ff) begin
         ramp_clamped = lim_max_ff;
      end else if (ramp_raw < lim_min_ff) begin
         ramp_clamped = lim_min_ff;
      end else begin
         ramp_clamped = ramp_raw;
      end
   end

   // The low phase is what remains of the period, never below zero.
   assign low_diff  = {1'b0, period_ff} - {1'b0, now_ff};
   assign low_count = low_diff[VAL_W] ? '0 : low_diff[VAL_W-1:0];
   assign moving    = (idx_ff < total_ff);

   always_comb begin
      state_in     = state_ff;
      enable_in    = enable_ff;
      period_in    = period_ff;
      lim_min_in   = lim_min_ff;
      lim_max_in   = lim_max_ff;
      now_in       = now_ff;
      start_in     = start_ff;
      target_in    = target_ff;
      idx_in       = idx_ff;
      total_in     = total_ff;
      neg_in       = neg_ff;
      upd_in       = upd_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      mul_start    = 1'b0;
      mul_mcand    = '0;
      mul_mplr     = '0;
      div_start    = 1'b0;

      // Configuration writes must be issued only while the block is idle; the block itself does not enforce it.
      if (csr_we) begin
         case (csr_index)
            REG_ENABLE:    enable_in  = csr_wdata[0];
            REG_PERIOD:    period_in  = csr_wdata;
            REG_LIMIT_MIN: lim_min_in = csr_wdata;
            REG_LIMIT_MAX: lim_max_in = csr_wdata;
            default:       ;
         endcase
      end

      if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               state_in = S_OUT;
               upd_in   = 1'b0;
               case (req_func)
                  FUNC_TICK: begin
                     // The index is below the total, so the increment cannot wrap
                     // and the product over the total stays within 16 bits.
                     if (enable_ff && moving) begin
                        idx_in    = idx_ff + VAL_W'(1);
                        neg_in    = (target_ff < start_ff);
                        mul_start = 1'b1;
                        mul_mcand = (target_ff < start_ff) ? (start_ff - target_ff)
                                                           : (target_ff - start_ff);
                        mul_mplr  = idx_ff + VAL_W'(1);
                        upd_in    = 1'b1;
                        state_in  = S_MUL;
                     end
                  end
                  FUNC_MOVE: begin
                     target_in = tgt_clamped;
                     start_in  = now_ff;
                     total_in  = (req_steps == '0) ? VAL_W'(1) : req_steps;
                     idx_in    = '0;
                     upd_in    = 1'b1;
                  end
                  FUNC_SET: begin
                     now_in    = req_target;
                     start_in  = req_target;
                     target_in = req_target;
                     idx_in    = '0;
                     total_in  = '0;
                     upd_in    = 1'b1;
                  end
                  default: ;
               endcase
            end
         end
         S_MUL: begin
            if (mul_done) begin
               div_start = 1'b1;
               state_in  = S_DIV;
            end
         end
         S_DIV: begin
            if (div_done) begin
               now_in   = ramp_clamped;
               state_in = S_OUT;
            end
         end
         S_OUT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {{(RSP_DATA_W - 2*VAL_W - 2){1'b0}},
                               moving, upd_ff, low_count, now_ff};
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         enable_ff    <= 1'b0;
         period_ff    <= '0;
         lim_min_ff   <= '0;
         lim_max_ff   <= '1;
         now_ff       <= '0;
         start_ff     <= '0;
         target_ff    <= '0;
         idx_ff       <= '0;
         total_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         enable_ff    <= enable_in;
         period_ff    <= period_in;
         lim_min_ff   <= lim_min_in;
         lim_max_ff   <= lim_max_in;
         now_ff       <= now_in;
         start_ff     <= start_in;
         target_ff    <= target_in;
         idx_ff       <= idx_in;
         total_ff     <= total_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      neg_ff      <= neg_in;
      upd_ff      <= upd_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // The span of the ramp times the step index, one bit per cycle.
   srv_mul #(.W(VAL_W)) u_mul (
      .clock   (clock),
      .reset   (reset),
      .start   (mul_start),
      .mcand   (mul_mcand),
      .mplr    (mul_mplr),
      .done    (mul_done),
      .product (mul_product)
   );

   // That product over the step total, one quotient bit per cycle.
   srv_div #(.W(VAL_W)) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (mul_product),
      .divisor  (total_ff),
      .done     (div_done),
      .quotient (div_quot)
   );

   // The step index never passes the step total; the divider relies on it.
   `SRV_ASSERT_IMP(a_idx_within_total, 1'b1, idx_ff <= total_ff, "step index beyond total")
   // A finished product is handed straight to the divider.
   `SRV_ASSERT_NXT(a_mul_to_div, mul_done, state_ff == S_DIV, "product not passed on")
   // A new result appears only when the controller retires an item.
   `SRV_ASSERT_IMP(a_rsp_from_out, $rose(rsp_tvalid), $past(state_ff) == S_OUT,
                   "result without a retiring item")

endmodule

`default_nettype wire
